>>> sv/rgbhsv_pkg.sv
// shared types and constants for the rgb to hsv pixel pipeline
// no dependencies; imported by the top level and its checker
package rgbhsv_pkg;

   localparam int unsigned CHAN_W    = 8;
   localparam int unsigned SAT_REM_W = 16;  // holds 255 * delta
   localparam int unsigned HUE_REM_W = 13;  // holds 30 * |diff|
   localparam int unsigned HUE_QUO_W = 5;   // hue quotient never exceeds 30
   localparam int unsigned DIV_STEPS = 8;   // one saturation quotient bit per stage

   localparam logic [CHAN_W-1:0] HUE_BASE_GREEN = 8'd60;
   localparam logic [CHAN_W-1:0] HUE_BASE_BLUE  = 8'd120;
   localparam logic [CHAN_W-1:0] HUE_WRAP       = 8'd180;
   localparam logic [CHAN_W-1:0] HUE_LIMIT      = 8'd180;

   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } sector_type;

   typedef struct packed {
      logic [CHAN_W-1:0] maxv;
      logic [CHAN_W-1:0] delta;
      logic [CHAN_W-1:0] absdiff;
      logic              neg;
      sector_type        sector;
   } front_type;

   typedef struct packed {
      logic [SAT_REM_W-1:0] s_rem;
      logic [CHAN_W-1:0]    s_quo;
      logic [HUE_REM_W-1:0] h_rem;
      logic [HUE_QUO_W-1:0] h_quo;
      logic [CHAN_W-1:0]    maxv;
      logic [CHAN_W-1:0]    delta;
      logic                 neg;
      sector_type           sector;
   } div_type;

endpackage

>>> sv/rgb_to_hsv_pixel.sv
// rgb to hsv pixel converter: 11-stage pipeline with two restoring dividers
// depends on rgbhsv_pkg
// a req beat reaches the rsp port through the front, div[0..8] and out registers
// throughput: one pixel per cycle while the output is not stalled, set by the one-bit-per-stage dividers
// each stage holds its own valid bit and fills any bubble ahead of a stall
// reset: synchronous, clears every valid bit; payload registers are not reset
module rgb_to_hsv_pixel (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [rgbhsv_pkg::CHAN_W-1:0] req_red,
   input  logic [rgbhsv_pkg::CHAN_W-1:0] req_green,
   input  logic [rgbhsv_pkg::CHAN_W-1:0] req_blue,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [rgbhsv_pkg::CHAN_W-1:0] rsp_hue,
   output logic [rgbhsv_pkg::CHAN_W-1:0] rsp_saturation,
   output logic [rgbhsv_pkg::CHAN_W-1:0] rsp_brightness
);
   import rgbhsv_pkg::*;

   // ---------------------------------------------------------------
   // stage layout
   //   front    : max, min, sector, delta, |diff| and its sign
   //   div[0]   : scale numerators, 255*delta and 30*|diff|
   //   div[1..8]: one quotient bit per stage, saturation bits 7..0,
   //              hue bits 4..0 in the last five of those stages
   //   out      : hue sector offset, floor fixup, wrap, special cases
   // ---------------------------------------------------------------

   front_type         front_ff, front_in;
   logic              front_v_ff;
   logic              front_rdy;

   div_type           div_ff  [0:DIV_STEPS];
   div_type           div_in  [0:DIV_STEPS];
   logic [DIV_STEPS:0] div_v_ff;
   logic [DIV_STEPS:0] div_rdy;

   logic [CHAN_W-1:0] hue_ff, hue_in;
   logic [CHAN_W-1:0] sat_ff, sat_in;
   logic [CHAN_W-1:0] bri_ff, bri_in;
   logic              out_v_ff;
   logic              out_rdy;

   // ready chain: a stage takes a beat when it is empty or its content moves on
   assign out_rdy   = !out_v_ff || rsp_ready;
   assign div_rdy[DIV_STEPS] = !div_v_ff[DIV_STEPS] || out_rdy;
   genvar gi;
   generate
      for (gi = 0; gi < DIV_STEPS; gi++) begin : g_rdy
         assign div_rdy[gi] = !div_v_ff[gi] || div_rdy[gi+1];
      end
   endgenerate
   assign front_rdy = !front_v_ff || div_rdy[0];
   assign req_ready = front_rdy;

   // front stage: extremes and sector, red wins ties over green, green over blue
   always_comb begin
      logic [CHAN_W-1:0] mx;
      logic [CHAN_W-1:0] mn;
      logic [CHAN_W:0]   diff;
      mx = req_red;
      if (req_green > mx) mx = req_green;
      if (req_blue > mx) mx = req_blue;
      mn = req_red;
      if (req_green < mn) mn = req_green;
      if (req_blue < mn) mn = req_blue;
      priority if (req_red >= req_green && req_red >= req_blue) begin
         front_in.sector = SECT_RED;
         diff = {1'b0, req_green} - {1'b0, req_blue};
      end else if (req_green >= req_blue) begin
         front_in.sector = SECT_GREEN;
         diff = {1'b0, req_blue} - {1'b0, req_red};
      end else begin
         front_in.sector = SECT_BLUE;
         diff = {1'b0, req_red} - {1'b0, req_green};
      end
      front_in.maxv    = mx;
      front_in.delta   = mx - mn;
      front_in.neg     = diff[CHAN_W];
      front_in.absdiff = diff[CHAN_W] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
   end

   // numerator scaling by shift and subtract
   always_comb begin
      div_in[0].s_rem  = {front_ff.delta, 8'b0} - SAT_REM_W'(front_ff.delta);
      div_in[0].h_rem  = (HUE_REM_W'(front_ff.absdiff) << 5)
                       - (HUE_REM_W'(front_ff.absdiff) << 1);
      div_in[0].s_quo  = '0;
      div_in[0].h_quo  = '0;
      div_in[0].maxv   = front_ff.maxv;
      div_in[0].delta  = front_ff.delta;
      div_in[0].neg    = front_ff.neg;
      div_in[0].sector = front_ff.sector;
   end

   // restoring division steps; quotients are known to fit, so the trial
   // subtrahend is simply the divisor shifted to the bit under test
   generate
      for (gi = 0; gi < DIV_STEPS; gi++) begin : g_div
         localparam int unsigned SBIT = DIV_STEPS - 1 - gi;
         always_comb begin
            logic [SAT_REM_W-1:0] s_try;
            logic [HUE_REM_W-1:0] h_try;
            div_in[gi+1] = div_ff[gi];
            s_try = SAT_REM_W'(div_ff[gi].maxv) << SBIT;
            h_try = HUE_REM_W'(div_ff[gi].delta) << SBIT;
            if (div_ff[gi].s_rem >= s_try) begin
               div_in[gi+1].s_rem       = div_ff[gi].s_rem - s_try;
               div_in[gi+1].s_quo[SBIT] = 1'b1;
            end
            if (SBIT < HUE_QUO_W) begin
               if (div_ff[gi].h_rem >= h_try) begin
                  div_in[gi+1].h_rem = div_ff[gi].h_rem - h_try;
                  div_in[gi+1].h_quo[SBIT % HUE_QUO_W] = 1'b1;
               end
            end
         end
      end
   endgenerate

   // output stage: floor of a negative ratio is minus the ceiling of its magnitude
   always_comb begin
      div_type           d;
      logic [CHAN_W-1:0] mag;
      logic [CHAN_W-1:0] base;
      d   = div_ff[DIV_STEPS];
      mag = CHAN_W'(d.h_quo) + CHAN_W'(d.neg && (d.h_rem != '0));
      unique case (d.sector)
         SECT_RED:   base = '0;
         SECT_GREEN: base = HUE_BASE_GREEN;
         SECT_BLUE:  base = HUE_BASE_BLUE;
         default:    base = '0;
      endcase
      priority if (d.delta == '0) begin
         hue_in = '0;                    // gray pixel has no sector
      end else if (!d.neg) begin
         hue_in = base + mag;
      end else if (d.sector == SECT_RED && mag != '0) begin
         hue_in = HUE_WRAP - mag;        // negative red hue wraps around
      end else begin
         hue_in = base - mag;
      end
      sat_in = (d.maxv == '0) ? '0 : d.s_quo;  // black pixel
      bri_in = d.maxv;
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (front_rdy && req_valid) front_ff <= front_in;
      if (out_rdy && div_v_ff[DIV_STEPS]) begin
         hue_ff <= hue_in;
         sat_ff <= sat_in;
         bri_ff <= bri_in;
      end
   end

   always_ff @(posedge clock) begin
      if (div_rdy[0] && front_v_ff) div_ff[0] <= div_in[0];
   end

   generate
      for (gi = 0; gi < DIV_STEPS; gi++) begin : g_div_reg
         always_ff @(posedge clock) begin
            if (div_rdy[gi+1] && div_v_ff[gi]) div_ff[gi+1] <= div_in[gi+1];
         end
      end
   endgenerate

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         front_v_ff <= 1'b0;
         div_v_ff   <= '0;
         out_v_ff   <= 1'b0;
      end else begin
         if (front_rdy) front_v_ff <= req_valid;
         if (div_rdy[0]) div_v_ff[0] <= front_v_ff;
         for (int k = 0; k < DIV_STEPS; k++) begin
            if (div_rdy[k+1]) div_v_ff[k+1] <= div_v_ff[k];
         end
         if (out_rdy) out_v_ff <= div_v_ff[DIV_STEPS];
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_hue        = hue_ff;
   assign rsp_saturation = sat_ff;
   assign rsp_brightness = bri_ff;

endmodule

>>> sv/rgbhsv_checker.sv
// port-level checker for rgb_to_hsv_pixel, attached by bind
// depends on rgbhsv_pkg
module rgbhsv_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [rgbhsv_pkg::CHAN_W-1:0] rsp_hue,
   input logic [rgbhsv_pkg::CHAN_W-1:0] rsp_saturation,
   input logic [rgbhsv_pkg::CHAN_W-1:0] rsp_brightness
);
   import rgbhsv_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hue)
         && $stable(rsp_saturation) && $stable(rsp_brightness))
      else $error("stalled rsp beat changed");

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hue < HUE_LIMIT)
      else $error("hue out of range");

   a_black_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_brightness == '0 |-> rsp_saturation == '0)
      else $error("black pixel with nonzero saturation");

   // zero saturation means delta is zero, so hue must be zero too
   a_gray_hue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturation == '0 |-> rsp_hue == '0)
      else $error("gray pixel with nonzero hue");

endmodule

bind rgb_to_hsv_pixel rgbhsv_checker u_rgbhsv_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_hue        (rsp_hue),
   .rsp_saturation (rsp_saturation),
   .rsp_brightness (rsp_brightness)
);
